FILE: rtl/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Shared types, frame positions and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int CountWidth = 3;

   localparam logic [CountWidth-1:0] POS_FIRST   = 3'd0;
   localparam logic [CountWidth-1:0] POS_READ_LO = 3'd3;
   localparam logic [CountWidth-1:0] POS_READ_HI = 3'd4;
   localparam logic [CountWidth-1:0] POS_CRC_LO  = 3'd5;
   localparam logic [CountWidth-1:0] POS_LAST    = 3'd6;
   localparam logic [CountWidth-1:0] POS_UNUSED  = 3'd7;

   localparam int FifoDepth    = 2;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = $clog2(FifoDepth + 1);

   localparam int ScaleShift = 5;
   localparam logic [11:0] SCALE_ROUND   = 12'd2047;
   localparam logic [12:0] SCALE_DIVISOR = 13'd4095;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } sfcc_req_type;

   typedef struct packed {
      logic        crc_ok;
      logic [15:0] raw_reading;
      logic [21:0] scaled_value;
      logic [15:0] computed_crc;
   } sfcc_rsp_type;

   typedef struct packed {
      logic        crc_ok;
      logic [15:0] raw_reading;
      logic [15:0] computed_crc;
   } sfcc_frame_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sfcc_front.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker front end
// Counts frame bytes, runs the CRC and captures the reading and received CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire sfcc_pkg::sfcc_req_type  req,
   output logic                         frame_valid,
   output sfcc_pkg::sfcc_frame_type     frame
);
   import sfcc_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [15:0]           crc_ff, crc_in;
   logic [15:0]           reading_ff, reading_in;
   logic [7:0]            crc_low_ff, crc_low_in;

   logic                  restart;
   logic [CountWidth-1:0] pos;
   logic [15:0]           crc_base;

   assign restart  = req.frame_start || (count_ff == POS_UNUSED);
   assign pos      = restart ? POS_FIRST : count_ff;
   assign crc_base = restart ? CRC_INIT : crc_ff;

   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      reading_in  = reading_ff;
      crc_low_in  = crc_low_ff;
      frame_valid = 1'b0;
      frame.crc_ok       = ({req.rx_byte, crc_low_ff} == crc_base);
      frame.raw_reading  = reading_ff;
      frame.computed_crc = crc_base;
      if (accept) begin
         crc_in   = (pos < POS_CRC_LO) ? crc_byte(crc_base, req.rx_byte) : crc_base;
         count_in = pos + 3'd1;
         unique case (pos)
            POS_READ_LO: reading_in = {reading_ff[15:8], req.rx_byte};
            POS_READ_HI: reading_in = {req.rx_byte, reading_ff[7:0]};
            POS_CRC_LO:  crc_low_in = req.rx_byte;
            POS_LAST: begin
               frame_valid = 1'b1;
               count_in    = POS_FIRST;
               crc_in      = CRC_INIT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= POS_FIRST;
         crc_ff     <= CRC_INIT;
         reading_ff <= '0;
         crc_low_ff <= '0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         reading_ff <= reading_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sfcc_fifo.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker frame queue
// Short register queue between the front end and the scaling back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire sfcc_pkg::sfcc_frame_type  push_data,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           empty,
   output sfcc_pkg::sfcc_frame_type       head
);
   import sfcc_pkg::*;

   sfcc_frame_type            entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   localparam logic [FifoCntWidth-1:0] FULL_COUNT = FifoCntWidth'(FifoDepth);
   localparam logic [FifoPtrWidth-1:0] LAST_PTR   = FifoPtrWidth'(FifoDepth - 1);

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sfcc_back.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker back end
// Scales the reading by 2/4095 in Q.16 and holds the result for the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      frame_empty,
   input  wire sfcc_pkg::sfcc_frame_type  frame,
   output logic                           frame_pop,
   input  wire logic                      pop,
   output logic                           empty,
   output sfcc_pkg::sfcc_rsp_type         rsp_data
);
   import sfcc_pkg::*;

   logic         valid_ff, valid_in;
   sfcc_rsp_type rsp_ff;

   logic [20:0] raw_shift;
   logic [21:0] rem_sum;
   logic [9:0]  rem_hi;
   logic [12:0] fold_sum;
   logic [9:0]  rem_quot;
   logic [21:0] scaled;

   // Since 4096 is one more than 4095, raw * 2^17 splits into raw * 32 whole
   // quotients plus a remainder of raw * 32 that is folded the same way.
   always_comb begin
      raw_shift = {frame.raw_reading, {ScaleShift{1'b0}}};
      rem_sum   = {1'b0, raw_shift} + {10'd0, SCALE_ROUND};
      rem_hi    = rem_sum[21:12];
      fold_sum  = {3'd0, rem_hi} + {1'b0, rem_sum[11:0]};
      rem_quot  = rem_hi + {9'd0, (fold_sum >= SCALE_DIVISOR)};
      scaled    = frame.crc_ok ? ({1'b0, raw_shift} + {12'd0, rem_quot}) : '0;
   end

   assign frame_pop = !frame_empty && (!valid_ff || pop);
   assign valid_in  = frame_pop || (valid_ff && !pop);
   assign empty     = !valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         rsp_ff.crc_ok       <= frame.crc_ok;
         rsp_ff.raw_reading  <= frame.raw_reading;
         rsp_ff.scaled_value <= scaled;
         rsp_ff.computed_crc <= frame.computed_crc;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sensor_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker
// Checks 7-byte sensor replies with CRC-16 and reports the scaled reading.
//
// Bytes enter through a queue-style port: a byte transfers on a clock edge
// with push high and full low; frame_start marks the first byte of a frame.
// One byte is taken every cycle while full is low. After the seventh byte of
// a frame one result is produced: CRC match flag, raw reading, reading times
// 2/4095 in Q.16 (zero on a CRC mismatch) and the computed CRC. The result
// reaches rsp_data via the queue and output register, with empty low; it
// transfers on an edge with pop high and empty low. The front end (byte count
// and CRC) feeds a two-entry frame queue, and the back end scales the reading
// into an output register. While the reader stalls, results collect in the
// queue and the output register; full rises only when both are occupied, and
// bytes that end no frame are still taken while only the queue has space.
// Reset clears the byte count, sets the CRC to 0xFFFF and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_checker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire sfcc_pkg::sfcc_req_type  req_data,
   output logic                         empty,
   input  wire logic                    pop,
   output sfcc_pkg::sfcc_rsp_type       rsp_data
);
   import sfcc_pkg::*;

   logic           accept;
   logic           frame_valid;
   sfcc_frame_type frame;
   logic           fifo_full, fifo_empty, fifo_pop;
   sfcc_frame_type fifo_head;

   assign full   = fifo_full;
   assign accept = push && !fifo_full;

   sfcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   sfcc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_valid),
      .push_data (frame),
      .pop       (fifo_pop),
      .full      (fifo_full),
      .empty     (fifo_empty),
      .head      (fifo_head)
   );

   sfcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_empty (fifo_empty),
      .frame       (fifo_head),
      .frame_pop   (fifo_pop),
      .pop         (pop),
      .empty       (empty),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker testbench
// Sends directed and random byte streams through the queue-style input, with
// random gaps and one long reader stall, and compares every reply against a
// cycle-free model of the frame counter, CRC-16 and reading scaler.
// ----------------------------------------------------------------------------

module testbench;

   import sfcc_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic [1:0] {FILL_NONE, FILL_CRC_LO, FILL_CRC_HI} crc_fill_type;

   typedef struct packed {
      logic [7:0]   value;
      logic         start;
      crc_fill_type fill;
      logic         typed;
      sfcc_rsp_type reply;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 24;

   // The first frame arrives before any frame_start, the second swaps its CRC
   // bytes, a partial frame is then cut short, and the last frame carries the
   // largest reading with its own CRC filled in.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'h01, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h03, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h02, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hB8, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h44, 1'b0, FILL_NONE,   1'b1, '{1'b1, 16'h0000, 22'd0, 16'h44B8}},
      '{8'h01, 1'b1, FILL_NONE,   1'b0, '0},
      '{8'h03, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h02, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h44, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hB8, 1'b0, FILL_NONE,   1'b1, '{1'b0, 16'h0000, 22'd0, 16'h44B8}},
      '{8'hFF, 1'b1, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b1, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, '0},
      '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, '0},
      '{8'h00, 1'b0, FILL_CRC_HI, 1'b0, '0}
   };

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   sfcc_req_type req_data;
   logic         empty;
   logic         pop;
   sfcc_rsp_type rsp_data;

   logic         hold_off;
   int           items_sent;
   int           error_count;
   int           cycle_count;

   logic [CountWidth-1:0] frame_pos;
   logic [15:0]           crc_run;
   logic [15:0]           reading_acc;
   logic [7:0]            crc_low_byte;

   sfcc_rsp_type pending_replies [$];

   sensor_frame_crc_checker dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic take_byte(input logic [7:0] value, input logic start,
                            output logic produced, output sfcc_rsp_type reply);
      logic [CountWidth-1:0] pos;
      logic [15:0]           rx_crc;
      logic [63:0]           product;
      produced = 1'b0;
      reply = '0;
      if (start || frame_pos == POS_UNUSED) begin
         frame_pos = POS_FIRST;
         crc_run = CRC_INIT;
      end
      pos = frame_pos;
      if (pos < POS_CRC_LO) begin
         crc_run = crc_run ^ {8'h00, value};
         for (int k = 0; k < 8; k++) begin
            crc_run = crc_run[0] ? ((crc_run >> 1) ^ CRC_POLY) : (crc_run >> 1);
         end
      end
      case (pos)
         POS_READ_LO: reading_acc[7:0] = value;
         POS_READ_HI: reading_acc[15:8] = value;
         POS_CRC_LO: crc_low_byte = value;
         default: ;
      endcase
      if (pos == POS_LAST) begin
         rx_crc = {value, crc_low_byte};
         reply.crc_ok = (rx_crc == crc_run);
         reply.raw_reading = reading_acc;
         reply.computed_crc = crc_run;
         if (reply.crc_ok) begin
            product = ({48'd0, reading_acc} * 64'd131072 + 64'd2047) / 64'd4095;
            reply.scaled_value = product[21:0];
         end
         produced = 1'b1;
         frame_pos = POS_FIRST;
         crc_run = CRC_INIT;
      end else begin
         frame_pos = pos + 1'b1;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic start,
                            input logic use_typed, input sfcc_rsp_type typed_reply);
      logic         produced;
      sfcc_rsp_type reply;
      int           gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= '{rx_byte: value, frame_start: start};
      @(posedge clock);
      while (full) @(posedge clock);
      take_byte(value, start, produced, reply);
      if (produced) begin
         pending_replies.push_back(use_typed ? typed_reply : reply);
      end
      items_sent++;
   endtask

   task automatic check_reply(input sfcc_rsp_type got);
      sfcc_rsp_type want;
      if (pending_replies.size() == 0) begin
         report_mismatch("reply with none pending, computed_crc", got.computed_crc, 0);
      end else begin
         want = pending_replies.pop_front();
         if (got.crc_ok !== want.crc_ok)
            report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
         if (got.raw_reading !== want.raw_reading)
            report_mismatch("raw_reading", got.raw_reading, want.raw_reading);
         if (got.scaled_value !== want.scaled_value)
            report_mismatch("scaled_value", got.scaled_value, want.scaled_value);
         if (got.computed_crc !== want.computed_crc)
            report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
      end
   endtask

   initial begin
      int idle_left;
      idle_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_reply(rsp_data);
         if (idle_left > 0) begin
            idle_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
         end
         pop <= !hold_off && idle_left == 0;
      end
   end

   // The reader stalls for a long stretch while bytes keep coming, so that the
   // reply queue fills and full is raised.
   initial begin
      hold_off <= 1'b0;
      wait (items_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      stim_row_type row;
      logic [7:0]   value;
      logic [15:0]  reading;
      logic         first_start;
      logic         good_crc;
      int           kind;
      int           burst;
      items_sent = 0;
      error_count = 0;
      frame_pos = POS_FIRST;
      crc_run = CRC_INIT;
      reading_acc = '0;
      crc_low_byte = '0;
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         case (row.fill)
            FILL_CRC_LO: value = crc_run[7:0];
            FILL_CRC_HI: value = crc_run[15:8];
            default: value = row.value;
         endcase
         send_byte(value, row.start, row.typed, row.reply);
      end

      while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            if (frame_pos != POS_FIRST) first_start = ($urandom_range(0, 4) != 0);
            else first_start = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
               0: reading = 16'h0000;
               1: reading = 16'hFFFF;
               default: reading = 16'($urandom_range(0, 65535));
            endcase
            good_crc = ($urandom_range(0, 6) != 0);
            for (int k = 0; k < 7; k++) begin
               case (k)
                  3: value = reading[7:0];
                  4: value = reading[15:8];
                  5: value = good_crc ? crc_run[7:0]
                                      : crc_run[7:0] ^ (8'h01 << $urandom_range(0, 7));
                  6: value = crc_run[15:8];
                  default: value = 8'($urandom_range(0, 255));
               endcase
               send_byte(value, (k == 0) ? first_start : 1'b0, 1'b0, '0);
            end
         end else begin
            burst = (kind == 8) ? $urandom_range(1, 6) : $urandom_range(1, 10);
            for (int k = 0; k < burst; k++) begin
               if (kind == 8) first_start = (k == 0);
               else first_start = ($urandom_range(0, 3) == 0);
               send_byte(8'($urandom_range(0, 255)), first_start, 1'b0, '0);
            end
         end
      end
      push <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
